### rtl/psc_pkg.sv
package psc_pkg;

	localparam int MAX_LIMIT = 65536;
	localparam int LIM_W     = $clog2(MAX_LIMIT + 1);
	localparam int MEM_DEPTH = MAX_LIMIT / 2;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int SQ_W      = LIM_W + 2;
	localparam int J_W       = LIM_W + 1;
	localparam int CNT_W     = 13;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic next_cand;
		logic mark_init;
		logic mark_step;
		logic count_init;
		logic count_step;
		logic emit;
	} psc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic cand_done;
		logic marked;
		logic mark_done;
		logic count_done;
	} psc_status_t;

endpackage

### rtl/prime_sieve_counter_core.sv
// Sieve over odd numbers: odd candidates up to sqrt(limit) are checked, the odd multiples
// of each unmarked one are marked, then a counting walk reads the odd-number mark memory.
// Throughput: one transaction at a time; busy falls in the cycle that done pulses.
// Reset: arst_n asynchronous; afterwards every entry of the mark memory is cleared
// with busy high. done is a one-cycle strobe and the receiver cannot stall it.
module prime_sieve_counter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [psc_pkg::LIM_W-1:0]  limit,
	output logic                       done,
	output logic [psc_pkg::CNT_W-1:0]  prime_count
);

	psc_pkg::psc_cmd_t    cmd;
	psc_pkg::psc_status_t status;

	psc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	psc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.limit       (limit),
		.done        (done),
		.prime_count (prime_count)
	);

endmodule

### rtl/psc_mark_mem.sv
module psc_mark_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [psc_pkg::MEM_AW-1:0] waddr,
	input  logic                      wdata,
	input  logic [psc_pkg::MEM_AW-1:0] raddr,
	output logic                      rdata
);

	logic mem_q [psc_pkg::MEM_DEPTH];

	// read-first: a read and write to the same entry returns the old bit
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/psc_datapath.sv
module psc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  psc_pkg::psc_cmd_t           cmd,
	output psc_pkg::psc_status_t        status,
	input  logic [psc_pkg::LIM_W-1:0]   limit,
	output logic                        done,
	output logic [psc_pkg::CNT_W-1:0]   prime_count
);

	logic [psc_pkg::LIM_W-1:0]  lim_q;
	logic [psc_pkg::LIM_W-1:0]  i_q;
	logic [psc_pkg::SQ_W-1:0]   sq_q;
	logic [psc_pkg::J_W-1:0]    j_q;
	logic [psc_pkg::J_W-1:0]    step_q;
	logic [psc_pkg::LIM_W-1:0]  k_q;
	logic [psc_pkg::CNT_W-1:0]  cnt_q;
	logic [psc_pkg::CNT_W-1:0]  result_q;
	logic [psc_pkg::MEM_AW-1:0] clr_q;
	logic                       rd_valid_s1;
	logic                       done_q;

	logic                       mem_we;
	logic                       mem_wdata;
	logic [psc_pkg::MEM_AW-1:0] mem_waddr;
	logic [psc_pkg::MEM_AW-1:0] mem_raddr;
	logic                       mem_rdata;
	logic [psc_pkg::LIM_W-1:0]  lim_sat;

	// odd n lives at entry n >> 1
	assign mem_we    = cmd.clr_step | cmd.mark_step | cmd.count_step;
	assign mem_wdata = cmd.mark_step;
	assign mem_waddr = cmd.clr_step  ? clr_q :
	                   cmd.mark_step ? j_q[psc_pkg::MEM_AW:1] : k_q[psc_pkg::MEM_AW:1];
	assign mem_raddr = cmd.count_step ? k_q[psc_pkg::MEM_AW:1] : i_q[psc_pkg::MEM_AW:1];

	assign lim_sat = (limit > psc_pkg::LIM_W'(psc_pkg::MAX_LIMIT)) ?
	                 psc_pkg::LIM_W'(psc_pkg::MAX_LIMIT) : limit;

	psc_mark_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		status.clr_last   = &clr_q;
		status.cand_done  = (i_q >= lim_q) || (sq_q > psc_pkg::SQ_W'(lim_q));
		status.marked     = mem_rdata;
		status.mark_done  = j_q >= psc_pkg::J_W'(lim_q);
		status.count_done = k_q >= lim_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			rd_valid_s1 <= cmd.count_step;
			done_q      <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lim_q <= lim_sat;
			i_q   <= psc_pkg::LIM_W'(3);
			sq_q  <= psc_pkg::SQ_W'(9);
		end
		if (cmd.next_cand) begin
			i_q  <= i_q + psc_pkg::LIM_W'(2);
			// (i+2)^2 = i^2 + 4i + 4
			sq_q <= sq_q + {i_q, 2'b00} + psc_pkg::SQ_W'(4);
		end
		if (cmd.mark_init) begin
			j_q    <= psc_pkg::J_W'(i_q) + {i_q, 1'b0};
			step_q <= {i_q, 1'b0};
		end
		if (cmd.mark_step) begin
			j_q <= j_q + step_q;
		end
		if (cmd.count_init) begin
			k_q   <= psc_pkg::LIM_W'(3);
			cnt_q <= (lim_q > psc_pkg::LIM_W'(2)) ? psc_pkg::CNT_W'(1) : '0;
		end
		if (cmd.count_step) begin
			k_q <= k_q + psc_pkg::LIM_W'(2);
		end
		if (rd_valid_s1 && !mem_rdata && (cnt_q != '1)) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.emit) begin
			result_q <= cnt_q;
		end
	end

	assign done        = done_q;
	assign prime_count = result_q;

endmodule

### rtl/psc_ctrl.sv
module psc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  psc_pkg::psc_status_t status,
	output psc_pkg::psc_cmd_t    cmd,
	output logic                 busy
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CAND,
		ST_CHECK,
		ST_MARK,
		ST_COUNT,
		ST_DRAIN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CAND;
				end
			end
			ST_CAND: begin
				if (status.cand_done) begin
					cmd.count_init = 1'b1;
					state_nxt      = ST_COUNT;
				end else begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.marked) begin
					cmd.next_cand = 1'b1;
					state_nxt     = ST_CAND;
				end else begin
					cmd.mark_init = 1'b1;
					state_nxt     = ST_MARK;
				end
			end
			ST_MARK: begin
				if (status.mark_done) begin
					cmd.next_cand = 1'b1;
					state_nxt     = ST_CAND;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			ST_COUNT: begin
				// the count walk also clears every entry it reads
				if (status.count_done) begin
					state_nxt = ST_DRAIN;
				end else begin
					cmd.count_step = 1'b1;
				end
			end
			ST_DRAIN: begin
				cmd.emit  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/psc_checker.sv
module psc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [psc_pkg::CNT_W-1:0]  prime_count
);

	// a result only follows a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without preceding busy");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while still busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (prime_count <= psc_pkg::CNT_W'(6542)))
		else $error("prime count out of range");

endmodule

bind prime_sieve_counter_core psc_checker u_psc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.prime_count (prime_count)
);
